>>> rtl/core/brst_pkg.sv
// ----------------------------------------------------------------------------
// brst_pkg
// Shared types, constants and helpers for the button repeat / hold toggle.
// ----------------------------------------------------------------------------
package brst_pkg;

    localparam int TIME_W = 32;
    localparam int SP_W   = 12;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    typedef logic [TIME_W-1:0]      time_t;
    typedef logic signed [SP_W-1:0] sp_t;

    localparam logic [IDX_W-1:0] CFG_REPEAT_PERIOD = 3'd0;
    localparam logic [IDX_W-1:0] CFG_FAST_AFTER    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PROGRESS      = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MESSAGE       = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SP_INIT       = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SP_MIN        = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SP_MAX        = 3'd6;

    localparam logic [CFG_W-1:0] RST_REPEAT_PERIOD = 16'd300;
    localparam logic [CFG_W-1:0] RST_FAST_AFTER    = 16'd2000;
    localparam logic [CFG_W-1:0] RST_PROGRESS      = 16'd1600;
    localparam logic [CFG_W-1:0] RST_MESSAGE       = 16'd2000;
    localparam sp_t              RST_SP_INIT       = 12'sd930;
    localparam sp_t              RST_SP_MIN        = 12'sd0;
    localparam sp_t              RST_SP_MAX        = 12'sd1500;

    localparam logic [1:0] HOLD_NONE   = 2'd0;
    localparam logic [1:0] HOLD_TOGGLE = 2'd1;
    localparam logic [1:0] HOLD_MSG    = 2'd2;
    localparam logic [1:0] HOLD_REBOOT = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_TOGGLE = 4'b0010,
        PH_MSG    = 4'b0100,
        PH_REBOOT = 4'b1000
    } phase_t;

    typedef struct packed {
        time_t time_ms;
        logic  up_pressed;
        logic  down_pressed;
        logic  hold_pressed;
    } in_beat_t;

    typedef struct packed {
        sp_t        setpoint;
        logic       power_off;
        logic       changed;
        logic       safety_restart;
        logic       reboot_request;
        logic [1:0] hold_phase;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_W-1:0] repeat_period;
        logic [CFG_W-1:0] fast_after;
        logic [CFG_W-1:0] progress;
        logic [CFG_W-1:0] message;
        sp_t              sp_min;
        sp_t              sp_max;
    } cfg_t;

    typedef struct packed {
        logic fire;
        logic fast;
    } key_step_t;

    typedef struct packed {
        logic       busy;
        logic       changed;
        logic       restart;
        logic       reboot;
        logic       power_off;
        logic [1:0] hold_phase;
    } mode_res_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_IDLE:   code = HOLD_NONE;
            PH_TOGGLE: code = HOLD_TOGGLE;
            PH_MSG:    code = HOLD_MSG;
            PH_REBOOT: code = HOLD_REBOOT;
            default:   code = HOLD_NONE;
        endcase
        return code;
    endfunction

    function automatic sp_t sat_step(input sp_t sp, input logic neg, input logic fast,
                                     input sp_t lo, input sp_t hi);
        logic signed [SP_W+1:0] delta;
        logic signed [SP_W+1:0] v;
        logic signed [SP_W+1:0] lo_x;
        logic signed [SP_W+1:0] hi_x;
        delta = fast ? 14'sd10 : 14'sd1;
        if (neg)
            delta = -delta;
        lo_x = $signed({{2{lo[SP_W-1]}}, lo});
        hi_x = $signed({{2{hi[SP_W-1]}}, hi});
        v = $signed({{2{sp[SP_W-1]}}, sp}) + delta;
        if (v > hi_x)
            v = hi_x;
        if (v < lo_x)
            v = lo_x;
        return v[SP_W-1:0];
    endfunction

endpackage

>>> rtl/core/button_repeat_setpoint_and_hold_toggle.sv
// ----------------------------------------------------------------------------
// button_repeat_setpoint_and_hold_toggle
// Setpoint stepping with auto-repeat and acceleration, plus hold sequence.
// ----------------------------------------------------------------------------
//  channel | signals                        | beat
//  in      | in_valid, in_stall, in_data    | one button sample with time
//  out     | out_valid, out_stall, out_data | one result per sample
//  cfg     | cfg_wr_en, cfg_index, cfg_data | one register write
//
//  One sample per cycle while the output is not stalled; a result passes
//  through the input register and the output register. Setpoint, press and
//  phase state update as a sample moves from input to output register.
//  Reset clears the valid flags and the press and phase state and loads the
//  register defaults and the setpoint. A stalled output holds the output
//  register; the input register then fills and in_stall rises.
// ----------------------------------------------------------------------------
module button_repeat_setpoint_and_hold_toggle (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  brst_pkg::in_beat_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output brst_pkg::out_beat_t          out_data,
    input  logic                         cfg_wr_en,
    input  logic [brst_pkg::IDX_W-1:0]   cfg_index,
    input  logic [brst_pkg::CFG_W-1:0]   cfg_data
);
    import brst_pkg::*;

    cfg_t      cfg_reg;
    logic      in_vld_reg;
    in_beat_t  in_reg;
    logic      out_vld_reg;
    out_beat_t out_reg;
    sp_t       sp_reg, sp_next;
    sp_t       sp_mid;
    logic      advance;
    logic      key_en;
    key_step_t down_step, up_step;
    mode_res_t mode_res;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign key_en    = advance && !mode_res.busy;

    // setpoint_init only matters at reset, where the default is loaded anyway
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_period <= RST_REPEAT_PERIOD;
            cfg_reg.fast_after    <= RST_FAST_AFTER;
            cfg_reg.progress      <= RST_PROGRESS;
            cfg_reg.message       <= RST_MESSAGE;
            cfg_reg.sp_min        <= RST_SP_MIN;
            cfg_reg.sp_max        <= RST_SP_MAX;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_REPEAT_PERIOD: cfg_reg.repeat_period <= cfg_data;
                CFG_FAST_AFTER:    cfg_reg.fast_after    <= cfg_data;
                CFG_PROGRESS:      cfg_reg.progress      <= cfg_data;
                CFG_MESSAGE:       cfg_reg.message       <= cfg_data;
                CFG_SP_INIT:       ;
                CFG_SP_MIN:        cfg_reg.sp_min        <= cfg_data[SP_W-1:0];
                CFG_SP_MAX:        cfg_reg.sp_max        <= cfg_data[SP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_reg <= in_data;
    end

    brst_key u_down (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (key_en),
        .pressed (in_reg.down_pressed),
        .now     (in_reg.time_ms),
        .cfg     (cfg_reg),
        .step    (down_step)
    );

    brst_key u_up (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (key_en),
        .pressed (in_reg.up_pressed),
        .now     (in_reg.time_ms),
        .cfg     (cfg_reg),
        .step    (up_step)
    );

    brst_mode u_mode (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .hold  (in_reg.hold_pressed),
        .now   (in_reg.time_ms),
        .cfg   (cfg_reg),
        .res   (mode_res)
    );

    // down first, then up
    always_comb
    begin
        sp_mid = down_step.fire
               ? sat_step(sp_reg, 1'b1, down_step.fast, cfg_reg.sp_min, cfg_reg.sp_max)
               : sp_reg;
        sp_next = up_step.fire
                ? sat_step(sp_mid, 1'b0, up_step.fast, cfg_reg.sp_min, cfg_reg.sp_max)
                : sp_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= RST_SP_INIT;
        else if (advance)
            sp_reg <= sp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.setpoint       <= sp_next;
            out_reg.power_off      <= mode_res.power_off;
            out_reg.changed        <= down_step.fire || up_step.fire || mode_res.changed;
            out_reg.safety_restart <= mode_res.restart;
            out_reg.reboot_request <= mode_res.reboot;
            out_reg.hold_phase     <= mode_res.hold_phase;
        end
    end

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> !in_stall)
        else $error("input stall raised with empty input register");

    a_reboot_ends_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reboot_request |-> out_data.hold_phase == HOLD_NONE)
        else $error("reboot reported while a hold phase runs");

    a_restart_powers_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.safety_restart
            |-> !out_data.power_off && out_data.changed && out_data.hold_phase == HOLD_MSG)
        else $error("restart pulse without power-on toggle");

    a_keys_quiet_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mode_res.busy |-> !down_step.fire && !up_step.fire)
        else $error("step button acted during hold sequence");

endmodule

>>> rtl/core/brst_key.sv
// ----------------------------------------------------------------------------
// brst_key
// Press tracker for one step button: press edge and timed auto-repeat.
// ----------------------------------------------------------------------------
module brst_key (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                pressed,
    input  brst_pkg::time_t     now,
    input  brst_pkg::cfg_t      cfg,
    output brst_pkg::key_step_t step
);
    import brst_pkg::*;

    logic  active_reg, active_next;
    time_t start_reg, start_next;
    time_t last_reg, last_next;

    always_comb
    begin
        active_next = active_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        step        = '0;
        if (active_next && !pressed)
            active_next = 1'b0;
        if (!active_next && pressed)
        begin
            active_next = 1'b1;
            start_next  = now;
            last_next   = now;
            step.fire   = en;
        end
        else if (active_next && pressed && ((now - last_reg) > TIME_W'(cfg.repeat_period)))
        begin
            last_next = now;
            step.fire = en;
            step.fast = (now - start_reg) > TIME_W'(cfg.fast_after);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
            last_reg   <= '0;
        end
        else if (en)
        begin
            active_reg <= active_next;
            start_reg  <= start_next;
            last_reg   <= last_next;
        end
    end

endmodule

>>> rtl/core/brst_mode.sv
// ----------------------------------------------------------------------------
// brst_mode
// Hold-button sequencer: toggle progress, message dwell, reboot progress.
// ----------------------------------------------------------------------------
module brst_mode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                hold,
    input  brst_pkg::time_t     now,
    input  brst_pkg::cfg_t      cfg,
    output brst_pkg::mode_res_t res
);
    import brst_pkg::*;

    logic   active_reg, active_next;
    time_t  start_reg, start_next;
    time_t  last_reg, last_next;
    time_t  ph_start_reg, ph_start_next;
    phase_t phase_reg, phase_next;
    logic   power_off_reg, power_off_next;
    time_t  elapsed;
    logic [CFG_W+1:0] start_limit;
    logic   changed, restart, reboot;

    assign elapsed     = now - ph_start_reg;
    assign start_limit = {2'b00, cfg.repeat_period} + {1'b0, cfg.repeat_period, 1'b0};

    always_comb
    begin
        active_next    = active_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        ph_start_next  = ph_start_reg;
        phase_next     = phase_reg;
        power_off_next = power_off_reg;
        changed        = 1'b0;
        restart        = 1'b0;
        reboot         = 1'b0;
        if (active_next && !hold)
        begin
            active_next = 1'b0;
            last_next   = '0;
            if (phase_next != PH_IDLE)
            begin
                phase_next = PH_IDLE;
                changed    = 1'b1;
            end
        end
        if (!active_next && hold)
        begin
            active_next = 1'b1;
            start_next  = now;
            last_next   = now;
        end
        if (active_next && hold)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if ((now - last_next) > TIME_W'(cfg.repeat_period))
                    begin
                        last_next = now;
                        if ((now - start_next) > TIME_W'(start_limit))
                        begin
                            phase_next    = PH_TOGGLE;
                            ph_start_next = now;
                            changed       = 1'b1;
                        end
                    end
                end
                PH_TOGGLE:
                begin
                    if (elapsed >= TIME_W'(cfg.progress))
                    begin
                        restart        = power_off_reg;
                        power_off_next = !power_off_reg;
                        changed        = 1'b1;
                        phase_next     = PH_MSG;
                        ph_start_next  = now;
                    end
                end
                PH_MSG:
                begin
                    if (elapsed >= TIME_W'(cfg.message))
                    begin
                        phase_next    = PH_REBOOT;
                        ph_start_next = now;
                    end
                end
                PH_REBOOT:
                begin
                    if (elapsed >= TIME_W'(cfg.progress))
                    begin
                        reboot     = 1'b1;
                        phase_next = PH_IDLE;
                        start_next = now;
                        last_next  = now;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.busy       = phase_reg != PH_IDLE;
        res.changed    = changed;
        res.restart    = restart;
        res.reboot     = reboot;
        res.power_off  = power_off_next;
        res.hold_phase = phase_code(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            start_reg     <= '0;
            last_reg      <= '0;
            ph_start_reg  <= '0;
            phase_reg     <= PH_IDLE;
            power_off_reg <= 1'b0;
        end
        else if (en)
        begin
            active_reg    <= active_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            ph_start_reg  <= ph_start_next;
            phase_reg     <= phase_next;
            power_off_reg <= power_off_next;
        end
    end

endmodule

>>> verif/setpoint_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// setpoint_checker
// Watches the sample and result channels of the setpoint / hold toggle block,
// tracks register writes, predicts each result beat from the accepted sample
// beats and compares every accepted result field by field in order.
// ----------------------------------------------------------------------------
module setpoint_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  brst_pkg::in_beat_t           in_data,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  brst_pkg::out_beat_t          out_data,
    input  logic                         cfg_wr_en,
    input  logic [brst_pkg::IDX_W-1:0]   cfg_index,
    input  logic [brst_pkg::CFG_W-1:0]   cfg_data,
    output int                           mismatch_count,
    output int                           results_owed
);
    import brst_pkg::*;

    localparam int KEY_DOWN = 0;
    localparam int KEY_UP   = 1;

    logic [CFG_W-1:0] rep_ms;
    logic [CFG_W-1:0] fast_ms;
    logic [CFG_W-1:0] prog_ms;
    logic [CFG_W-1:0] msg_ms;
    sp_t              sp_lo;
    sp_t              sp_hi;

    sp_t              sp_now;
    logic             pwr_off;
    logic             key_on [2];
    time_t            key_t0 [2];
    time_t            key_tl [2];
    logic             hold_on;
    time_t            hold_t0;
    time_t            hold_tl;
    logic [1:0]       stage;
    time_t            stage_t0;

    out_beat_t        owed_results [$];

    function automatic sp_t clamp_setpoint(input sp_t v, input int delta,
                                           input sp_t lo, input sp_t hi);
        int s;
        s = int'(v) + delta;
        if (s > int'(hi))
            s = int'(hi);
        if (s < int'(lo))
            s = int'(lo);
        return s[SP_W-1:0];
    endfunction

    task automatic advance_panel(input in_beat_t b, output out_beat_t r);
        time_t      t;
        time_t      el;
        time_t      rep32;
        time_t      three_rep;
        logic [1:0] keys;
        int         sgn;
        logic       busy;
        logic       chg;
        logic       restart;
        logic       reboot;
        t         = b.time_ms;
        keys      = {b.up_pressed, b.down_pressed};
        rep32     = {16'd0, rep_ms};
        three_rep = rep32 * 32'd3;
        busy      = (stage != HOLD_NONE);
        chg       = 1'b0;
        restart   = 1'b0;
        reboot    = 1'b0;

        if (!busy) begin
            for (int k = KEY_DOWN; k <= KEY_UP; k++) begin
                sgn = (k == KEY_UP) ? 1 : -1;
                if (key_on[k] && !keys[k])
                    key_on[k] = 1'b0;
                if (!key_on[k] && keys[k]) begin
                    key_on[k] = 1'b1;
                    key_t0[k] = t;
                    key_tl[k] = t;
                    sp_now    = clamp_setpoint(sp_now, sgn, sp_lo, sp_hi);
                    chg       = 1'b1;
                end
                else if (key_on[k] && keys[k] && (t - key_tl[k]) > rep32) begin
                    key_tl[k] = t;
                    if ((t - key_t0[k]) > {16'd0, fast_ms})
                        sgn = sgn * 10;
                    sp_now = clamp_setpoint(sp_now, sgn, sp_lo, sp_hi);
                    chg    = 1'b1;
                end
            end
        end

        if (hold_on && !b.hold_pressed) begin
            hold_on = 1'b0;
            hold_tl = '0;
            if (stage != HOLD_NONE) begin
                stage = HOLD_NONE;
                chg   = 1'b1;
            end
        end
        if (!hold_on && b.hold_pressed) begin
            hold_on = 1'b1;
            hold_t0 = t;
            hold_tl = t;
        end

        if (hold_on && b.hold_pressed) begin
            el = t - stage_t0;
            case (stage)
                HOLD_NONE: begin
                    if ((t - hold_tl) > rep32) begin
                        hold_tl = t;
                        if ((t - hold_t0) > three_rep) begin
                            stage    = HOLD_TOGGLE;
                            stage_t0 = t;
                            chg      = 1'b1;
                        end
                    end
                end
                HOLD_TOGGLE: begin
                    if (el >= {16'd0, prog_ms}) begin
                        restart  = pwr_off;
                        pwr_off  = !pwr_off;
                        chg      = 1'b1;
                        stage    = HOLD_MSG;
                        stage_t0 = t;
                    end
                end
                HOLD_MSG: begin
                    if (el >= {16'd0, msg_ms}) begin
                        stage    = HOLD_REBOOT;
                        stage_t0 = t;
                    end
                end
                default: begin
                    if (el >= {16'd0, prog_ms}) begin
                        reboot  = 1'b1;
                        stage   = HOLD_NONE;
                        hold_t0 = t;
                        hold_tl = t;
                    end
                end
            endcase
        end

        r.setpoint       = sp_now;
        r.power_off      = pwr_off;
        r.changed        = chg;
        r.safety_restart = restart;
        r.reboot_request = reboot;
        r.hold_phase     = stage;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_beat_t want;
        out_beat_t next_result;
        if (!rst_n) begin
            rep_ms   = RST_REPEAT_PERIOD;
            fast_ms  = RST_FAST_AFTER;
            prog_ms  = RST_PROGRESS;
            msg_ms   = RST_MESSAGE;
            sp_lo    = RST_SP_MIN;
            sp_hi    = RST_SP_MAX;
            sp_now   = RST_SP_INIT;
            pwr_off  = 1'b0;
            for (int k = KEY_DOWN; k <= KEY_UP; k++) begin
                key_on[k] = 1'b0;
                key_t0[k] = '0;
                key_tl[k] = '0;
            end
            hold_on  = 1'b0;
            hold_t0  = '0;
            hold_tl  = '0;
            stage    = HOLD_NONE;
            stage_t0 = '0;
            owed_results.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_REPEAT_PERIOD: rep_ms  = cfg_data;
                    CFG_FAST_AFTER:    fast_ms = cfg_data;
                    CFG_PROGRESS:      prog_ms = cfg_data;
                    CFG_MESSAGE:       msg_ms  = cfg_data;
                    CFG_SP_MIN:        sp_lo   = cfg_data[SP_W-1:0];
                    CFG_SP_MAX:        sp_hi   = cfg_data[SP_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, out_data);
                    mismatch_count++;
                end
                else begin
                    want = owed_results.pop_front();
                    if (out_data.setpoint !== want.setpoint)
                        report_mismatch("setpoint", $signed(want.setpoint),
                                        $signed(out_data.setpoint));
                    if (out_data.power_off !== want.power_off)
                        report_mismatch("power_off", want.power_off, out_data.power_off);
                    if (out_data.changed !== want.changed)
                        report_mismatch("changed", want.changed, out_data.changed);
                    if (out_data.safety_restart !== want.safety_restart)
                        report_mismatch("safety_restart", want.safety_restart,
                                        out_data.safety_restart);
                    if (out_data.reboot_request !== want.reboot_request)
                        report_mismatch("reboot_request", want.reboot_request,
                                        out_data.reboot_request);
                    if (out_data.hold_phase !== want.hold_phase)
                        report_mismatch("hold_phase", want.hold_phase, out_data.hold_phase);
                end
            end

            if (in_valid && !in_stall) begin
                advance_panel(in_data, next_result);
                owed_results.push_back(next_result);
            end

            results_owed = owed_results.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the setpoint / hold toggle block: a directed
// sequence at the reset registers, then random button sessions over several
// register settings and idle mixes, with a checker watching both channels.
// ----------------------------------------------------------------------------
module tb;
    import brst_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int LONG_HOLD         = 200;
    localparam int ITEMS_PER_SETTING = 305;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_beat_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_beat_t        out_data;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               mismatch_count;
    int               results_owed;
    int               cycle_count = 0;
    int               samples_sent = 0;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    logic             hold_req = 1'b0;
    int               hold_left;
    time_t            now_ms;
    int               cur_rep;
    int               cur_fast;
    int               cur_prog;
    int               cur_msg;

    button_repeat_setpoint_and_hold_toggle i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    setpoint_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** button_repeat_setpoint_and_hold_toggle: FAILED **");
        $finish;
    end

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic send_sample(input time_t t, input logic up, input logic down,
                               input logic hold);
        in_beat_t b;
        b.time_ms      = t;
        b.up_pressed   = up;
        b.down_pressed = down;
        b.hold_pressed = hold;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(negedge clk);
    endtask

    // drain all results, then reprogram every register
    task automatic load_settings(input int rp, input int fa, input int pr, input int ms,
                                 input int init, input int lo, input int hi);
        in_valid <= 1'b0;
        wait (results_owed == 0);
        repeat (4) @(negedge clk);
        write_reg(CFG_REPEAT_PERIOD, rp);
        write_reg(CFG_FAST_AFTER, fa);
        write_reg(CFG_PROGRESS, pr);
        write_reg(CFG_MESSAGE, ms);
        write_reg(CFG_SP_INIT, init);
        write_reg(CFG_SP_MIN, lo);
        write_reg(CFG_SP_MAX, hi);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        cur_rep  = rp;
        cur_fast = fa;
        cur_prog = pr;
        cur_msg  = ms;
    endtask

    function automatic time_t pick_dt(input int base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 10)
            return base;
        if (r < 16)
            return base + 1;
        if (r < 20)
            return base - 1;
        if (r < 96)
            return $urandom_range(1, 2 * base);
        return $urandom;
    endfunction

    task automatic random_block(input int count);
        int   stop;
        int   kind;
        int   n;
        int   base;
        int   pick;
        logic u;
        logic d;
        logic h;
        stop = samples_sent + count;
        pick = 0;
        while (samples_sent < stop)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                n    = $urandom_range(10, 60);
                base = $urandom_range(0, 1) ? cur_rep
                                            : ((cur_prog > cur_msg) ? cur_prog : cur_msg) / 4;
            end
            else if (kind < 85)
            begin
                n    = $urandom_range(4, 40);
                base = $urandom_range(0, 1) ? cur_rep : cur_fast / 4;
                pick = $urandom_range(1, 3);
            end
            else
            begin
                n    = $urandom_range(1, 8);
                base = cur_rep;
            end
            if (base < 1)
                base = 1;
            if (n > stop - samples_sent)
                n = stop - samples_sent;
            repeat (n)
            begin
                now_ms += pick_dt(base);
                if (kind < 55)
                begin
                    h = ($urandom_range(0, 99) >= 3);
                    u = ($urandom_range(0, 3) == 0);
                    d = ($urandom_range(0, 3) == 0);
                end
                else if (kind < 85)
                begin
                    u = pick[1] && ($urandom_range(0, 99) >= 5);
                    d = pick[0] && ($urandom_range(0, 99) >= 5);
                    h = ($urandom_range(0, 99) < 5);
                end
                else
                    {u, d, h} = 3'($urandom_range(0, 7));
                send_sample(now_ms, u, d, h);
            end
            if ((samples_sent < stop) && $urandom_range(0, 1))
            begin
                now_ms += pick_dt(cur_rep);
                send_sample(now_ms, 1'b0, 1'b0, 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_REPEAT_PERIOD;
        cfg_data  = '0;
        now_ms    = '0;
        cur_rep   = int'(RST_REPEAT_PERIOD);
        cur_fast  = int'(RST_FAST_AFTER);
        cur_prog  = int'(RST_PROGRESS);
        cur_msg   = int'(RST_MESSAGE);
        tx_idle_pct = 30;
        rx_idle_pct = 67;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // press edge, repeat, fast repeat, release, both keys
        send_sample(32'd1000, 1'b1, 1'b0, 1'b0);
        send_sample(32'd1200, 1'b1, 1'b0, 1'b0);
        send_sample(32'd1301, 1'b1, 1'b0, 1'b0);
        send_sample(32'd3400, 1'b1, 1'b0, 1'b0);
        send_sample(32'd3500, 1'b0, 1'b0, 1'b0);
        send_sample(32'd3600, 1'b1, 1'b1, 1'b0);
        send_sample(32'd3950, 1'b1, 1'b1, 1'b0);
        send_sample(32'd4000, 1'b0, 1'b0, 1'b0);
        // full hold sequence, keys ignored while busy
        send_sample(32'd10000, 1'b0, 1'b0, 1'b1);
        send_sample(32'd10301, 1'b0, 1'b0, 1'b1);
        send_sample(32'd10602, 1'b0, 1'b0, 1'b1);
        send_sample(32'd10903, 1'b0, 1'b0, 1'b1);
        send_sample(32'd11000, 1'b1, 1'b0, 1'b1);
        send_sample(32'd12503, 1'b0, 1'b1, 1'b1);
        send_sample(32'd14503, 1'b0, 1'b0, 1'b1);
        send_sample(32'd16103, 1'b0, 1'b0, 1'b1);
        send_sample(32'd16200, 1'b0, 1'b0, 1'b0);
        // toggle back on (safety restart), then abort in the message dwell
        send_sample(32'd20000, 1'b0, 1'b0, 1'b1);
        send_sample(32'd20301, 1'b0, 1'b0, 1'b1);
        send_sample(32'd20602, 1'b0, 1'b0, 1'b1);
        send_sample(32'd20903, 1'b0, 1'b0, 1'b1);
        send_sample(32'd22503, 1'b0, 1'b0, 1'b1);
        send_sample(32'd22600, 1'b0, 1'b0, 1'b0);
        // repeat across the time wrap
        send_sample(32'hFFFF_FF00, 1'b1, 1'b0, 1'b0);
        send_sample(32'h0000_0100, 1'b1, 1'b0, 1'b0);
        send_sample(32'h0000_0110, 1'b0, 1'b0, 1'b0);
        now_ms = 32'h0000_0110;

        random_block(ITEMS_PER_SETTING);

        load_settings(1, 1, 1, 1, -2048, -2048, 2047);
        random_block(ITEMS_PER_SETTING);

        tx_idle_pct = 67;
        rx_idle_pct = 30;
        load_settings(65535, 65535, 65535, 65535, 2047, -2048, 2047);
        now_ms = 32'hFFF0_0000;
        random_block(ITEMS_PER_SETTING);

        load_settings(5, 30, 20, 25, 0, -15, 15);
        random_block(ITEMS_PER_SETTING);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_settings(7, 40, 12, 9, 100, 50, 10);
        hold_req = 1'b1;
        random_block(ITEMS_PER_SETTING);

        load_settings($urandom_range(1, 40), $urandom_range(1, 400),
                      $urandom_range(1, 150), $urandom_range(1, 150),
                      int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048,
                      int'($urandom_range(0, 4095)) - 2048);
        hold_req = 1'b1;
        random_block(ITEMS_PER_SETTING);

        in_valid <= 1'b0;
        wait (results_owed == 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** button_repeat_setpoint_and_hold_toggle: PASSED **");
        else
            $display("** button_repeat_setpoint_and_hold_toggle: FAILED **");
        $finish;
    end

endmodule
